// File: rtl/core/pwm_pkg.sv
// shared types and constants for the partitioned word memory
// no dependencies; imported by every module of the block but pwm_ram
`default_nettype none

package pwm_pkg;

    // fixed field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned REGION_W = 2;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    // compare width, holds any byte address up to and including 65536
    localparam int unsigned CMP_W    = ADDR_W + 1;

    // stream widths: input fields 2 + 16 + 32 = 50 bits, padded to 56
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = CMD_W;
    localparam int unsigned OUT_TDATA_W = DATA_W;
    localparam int unsigned OUT_TUSER_W = STATUS_W;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ALIGN = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    // check results from the pointer bank to the sequencer
    typedef struct packed {
        logic              region_ok;  // region index below the region count
        logic              full;       // selected region has no free word
        logic              range_err;  // address at or above the memory size
        logic              align_err;  // address not a multiple of 4
        logic              access_ok;  // address below its region's pointer
        logic [DATA_W-1:0] alloc_addr; // selected region's next free byte address
    } t_ptr_rsp;

endpackage

`default_nettype wire

// File: rtl/core/pwm_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module pwm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/pwm_ptr.sv
// per-region allocation pointers and the address checks against them
// depends on pwm_pkg
`default_nettype none

module pwm_ptr
    import pwm_pkg::*;
#(
    parameter int unsigned REGION_WORDS = 64,
    parameter int unsigned REGION_COUNT = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [REGION_W-1:0] i_region,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic                i_advance,
    output t_ptr_rsp                 o_rsp
);

    localparam int unsigned REGION_BYTES = 4 * REGION_WORDS;
    localparam int unsigned TOTAL_BYTES  = REGION_BYTES * REGION_COUNT;
    localparam int unsigned PW  = $clog2(TOTAL_BYTES + 1);
    localparam int unsigned RIW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

    logic [PW-1:0]    r_ptr [REGION_COUNT];
    logic [RIW-1:0]   sel;
    logic [PW-1:0]    ptr_sel;
    logic [CMP_W-1:0] addr_x;
    logic [CMP_W-1:0] limit_sel;
    logic             hit;

    assign sel       = RIW'(i_region);
    assign ptr_sel   = r_ptr[sel];
    assign addr_x    = CMP_W'(i_addr);
    assign limit_sel = CMP_W'((32'(i_region) + 32'd1) * REGION_BYTES);

    // address lies in some region below that region's pointer
    always_comb begin
        hit = 1'b0;
        for (int r = 0; r < REGION_COUNT; r++) begin
            if (addr_x >= CMP_W'(r * REGION_BYTES) && addr_x < CMP_W'(r_ptr[r])) begin
                hit = 1'b1;
            end
        end
    end

    // check results
    always_comb begin
        o_rsp.region_ok  = 32'(i_region) < REGION_COUNT;
        o_rsp.full       = CMP_W'(ptr_sel) >= limit_sel;
        o_rsp.range_err  = addr_x >= CMP_W'(TOTAL_BYTES);
        o_rsp.align_err  = i_addr[1:0] != 2'b00;
        o_rsp.access_ok  = hit;
        o_rsp.alloc_addr = DATA_W'(ptr_sel);
    end

    // bump pointers, reset to the region bases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < REGION_COUNT; r++) begin
                r_ptr[r] <= PW'(r * REGION_BYTES);
            end
        end else if (i_advance) begin
            r_ptr[sel] <= ptr_sel + PW'(4);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pwm_ctrl.sv
// command sequencer: input capture, checks, ram access and the zeroing sweep
// depends on pwm_pkg
`default_nettype none

module pwm_ctrl
    import pwm_pkg::*;
#(
    parameter int unsigned REGION_WORDS = 64,
    parameter int unsigned REGION_COUNT = 4,
    parameter int unsigned AW = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input transaction
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [REGION_W-1:0] i_region,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic [DATA_W-1:0]   i_wval,
    // pointer bank
    output logic [REGION_W-1:0]      o_region,
    output logic [ADDR_W-1:0]        o_addr,
    output logic                     o_advance,
    input  wire t_ptr_rsp            i_rsp,
    // ram
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic [DATA_W-1:0]        o_wdata,
    output logic                     o_re,
    output logic [AW-1:0]            o_raddr,
    input  wire logic [DATA_W-1:0]   i_rdata,
    // result
    input  wire logic                i_slot_free,
    output logic                     o_res_valid,
    output logic [STATUS_W-1:0]      o_res_status,
    output logic [DATA_W-1:0]        o_res_data
);

    localparam int unsigned TOTAL_WORDS = REGION_WORDS * REGION_COUNT;

    localparam logic [2:0] S_WIPE   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [REGION_W-1:0] r_region;
    logic [ADDR_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_wval;
    logic [AW-1:0]       r_wa, n_wa;
    logic [AW-1:0]       r_wend, n_wend;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic                sweeping;
    logic                exec_wr;
    logic [AW-1:0]       word_idx;

    assign o_ready   = r_state == S_IDLE;
    assign o_region  = r_region;
    assign o_addr    = r_addr;
    assign word_idx  = r_addr[AW+1:2];
    assign sweeping  = r_state == S_WIPE || r_state == S_CLEAR;

    // ram port drive: sweep writes zero, an executed write stores its word
    assign o_we    = sweeping || exec_wr;
    assign o_waddr = sweeping ? r_wa : word_idx;
    assign o_wdata = sweeping ? '0 : r_wval;
    assign o_raddr = word_idx;

    assign o_res_valid  = r_state == S_RESP && i_slot_free;
    assign o_res_status = r_status;
    assign o_res_data   = r_data;

    // next state and result
    always_comb begin
        n_state   = r_state;
        n_wa      = r_wa;
        n_wend    = r_wend;
        n_status  = r_status;
        n_data    = r_data;
        o_advance = 1'b0;
        o_re      = 1'b0;
        exec_wr   = 1'b0;
        case (r_state)
            S_WIPE, S_CLEAR: begin
                if (r_wa == r_wend) begin
                    n_state = (r_state == S_WIPE) ? S_IDLE : S_RESP;
                end else begin
                    n_wa = r_wa + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = STAT_OK;
                n_data   = '0;
                n_state  = S_RESP;
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (!i_rsp.region_ok) begin
                            n_status = STAT_RANGE;
                        end else if (i_rsp.full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_data    = i_rsp.alloc_addr;
                            o_advance = 1'b1;
                        end
                    end
                    CMD_READ, CMD_WRITE: begin
                        if (i_rsp.range_err) begin
                            n_status = STAT_RANGE;
                        end else if (i_rsp.align_err) begin
                            n_status = STAT_ALIGN;
                        end else if (!i_rsp.access_ok) begin
                            n_status = STAT_RANGE;
                        end else if (r_cmd == CMD_READ) begin
                            o_re    = 1'b1;
                            n_state = S_RDWAIT;
                        end else begin
                            exec_wr = 1'b1;
                        end
                    end
                    default: begin
                        // clear region: sweep the region's word span
                        if (!i_rsp.region_ok) begin
                            n_status = STAT_RANGE;
                        end else begin
                            n_wa    = AW'(32'(r_region) * REGION_WORDS);
                            n_wend  = AW'(32'(r_region) * REGION_WORDS + REGION_WORDS - 1);
                            n_state = S_CLEAR;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                n_data  = i_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, wipe sweep starts at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_wa    <= '0;
            r_wend  <= AW'(TOTAL_WORDS - 1);
        end else begin
            r_state <= n_state;
            r_wa    <= n_wa;
            r_wend  <= n_wend;
        end
    end

    // captured transaction and result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        if (o_ready && i_valid) begin
            r_cmd    <= i_cmd;
            r_region <= i_region;
            r_addr   <= i_addr;
            r_wval   <= i_wval;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/partitioned_word_memory_top.sv
// top level of the partitioned word memory: stream ports and output register
// depends on pwm_pkg, pwm_ram, pwm_ptr, pwm_ctrl
`default_nettype none

// Word memory of REGION_COUNT regions of REGION_WORDS 32-bit words, each region
// with a bump allocation pointer. One transaction is in flight at a time; its
// result sits in an output register so the next transaction can be taken while
// the result waits. From acceptance to result the sequencer steps through
// capture, check and result; an executed read adds a wait for the registered
// ram read, and clear region adds a sweep that zeroes one word per cycle
// through the single ram write port. After reset a clearing pass zeroes all
// REGION_WORDS * REGION_COUNT words (256 by default), one word per cycle,
// during which no transaction is taken.
module partitioned_word_memory_top
    import pwm_pkg::*;
#(
    parameter int unsigned REGION_WORDS = 64,
    parameter int unsigned REGION_COUNT = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: region [1:0], byte_address [17:2], write_value [49:18], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd [1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: data [31:0]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: status [1:0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam int unsigned TOTAL_WORDS = REGION_WORDS * REGION_COUNT;
    localparam int unsigned AW = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

    logic [REGION_W-1:0] ptr_region;
    logic [ADDR_W-1:0]   ptr_addr;
    logic                ptr_advance;
    t_ptr_rsp            ptr_rsp;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                slot_free;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic [DATA_W-1:0]   res_data;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [DATA_W-1:0]   r_odata;

    pwm_ctrl #(
        .REGION_WORDS (REGION_WORDS),
        .REGION_COUNT (REGION_COUNT),
        .AW           (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser[CMD_W-1:0]),
        .i_region     (s_axis_tdata[1:0]),
        .i_addr       (s_axis_tdata[17:2]),
        .i_wval       (s_axis_tdata[49:18]),
        .o_region     (ptr_region),
        .o_addr       (ptr_addr),
        .o_advance    (ptr_advance),
        .i_rsp        (ptr_rsp),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res_status (res_status),
        .o_res_data   (res_data)
    );

    pwm_ptr #(
        .REGION_WORDS (REGION_WORDS),
        .REGION_COUNT (REGION_COUNT)
    ) u_ptr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_region  (ptr_region),
        .i_addr    (ptr_addr),
        .i_advance (ptr_advance),
        .o_rsp     (ptr_rsp)
    );

    pwm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TOTAL_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register frees when empty or taken this cycle
    assign slot_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_ostatus <= res_status;
            r_odata   <= res_data;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostatus;

endmodule

`default_nettype wire

// File: rtl/core/pwm_checker.sv
// port-level assertions for the partitioned word memory, bound to the top level
// depends on pwm_pkg and partitioned_word_memory_top
`default_nettype none

module pwm_checker
    import pwm_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   i_s_tready,
    input wire logic                   i_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    input wire logic [OUT_TUSER_W-1:0] i_m_tuser
);

    // a held result keeps its payload until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // one transaction at a time: ready drops right after an input transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken while a transaction is in flight");

    // an error result never carries data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == STAT_RANGE || i_m_tuser == STAT_ALIGN
            || i_m_tuser == STAT_FULL) |-> i_m_tdata == '0)
        else $error("error result with nonzero data");

    // memory clearing pass follows reset, no input taken at once
    a_wipe_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_s_tready && !i_m_tvalid)
        else $error("block ready straight out of reset");

endmodule

bind partitioned_word_memory_top pwm_checker u_pwm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for partitioned_word_memory_top: stream stimulus and in-order checks
// depends on pwm_pkg and the partitioned word memory rtl
`timescale 1ns / 1ps

module tb;
    import pwm_pkg::*;

    localparam int unsigned REGION_WORDS = 64;
    localparam int unsigned REGION_COUNT = 4;
    localparam int unsigned REGION_BYTES = 4 * REGION_WORDS;
    localparam int unsigned TOTAL_WORDS  = REGION_WORDS * REGION_COUNT;
    localparam int unsigned TOTAL_BYTES  = 4 * TOTAL_WORDS;
    localparam int unsigned PAD_W        = IN_TDATA_W - (REGION_W + ADDR_W + DATA_W);
    // settle time sized from clear region, the slowest transaction, plus margin
    localparam int unsigned SETTLE_CYCLES = REGION_WORDS + 12;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASE_ITEMS   = 250;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [REGION_W-1:0] region;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   wval;
    } mem_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
    } mem_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: region [1:0], byte_address [17:2], write_value [49:18], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: cmd [1:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: data [31:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status [1:0]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // shadow copy of the memory state
    logic [DATA_W-1:0] shadow_words [TOTAL_WORDS];
    logic [10:0]       shadow_next_free [REGION_COUNT];

    mem_result_t pending_results [$];
    int          error_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned rx_hold = 0;
    int unsigned quiet_cycles = 0;

    partitioned_word_memory_top #(
        .REGION_WORDS(REGION_WORDS),
        .REGION_COUNT(REGION_COUNT)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // predict one transaction and update the shadow state
    function automatic mem_result_t model_memory_op(mem_cmd_t c);
        mem_result_t r;
        int unsigned a;
        int unsigned owner;
        r.status = STAT_OK;
        r.data   = '0;
        a        = c.addr;
        case (c.cmd)
            CMD_ALLOC: begin
                if (c.region >= REGION_COUNT) begin
                    r.status = STAT_RANGE;
                end else if (shadow_next_free[c.region] >= (c.region + 1) * REGION_BYTES) begin
                    r.status = STAT_FULL;
                end else begin
                    r.data = DATA_W'(shadow_next_free[c.region]);
                    shadow_next_free[c.region] = shadow_next_free[c.region] + 11'd4;
                end
            end
            CMD_READ, CMD_WRITE: begin
                if (a >= TOTAL_BYTES) begin
                    r.status = STAT_RANGE;
                end else if (a[1:0] != 2'b00) begin
                    r.status = STAT_ALIGN;
                end else begin
                    owner = a / REGION_BYTES;
                    if (owner >= REGION_COUNT || a >= shadow_next_free[owner]) begin
                        r.status = STAT_RANGE;
                    end else if (c.cmd == CMD_READ) begin
                        r.data = shadow_words[a >> 2];
                    end else begin
                        shadow_words[a >> 2] = c.wval;
                    end
                end
            end
            default: begin
                if (c.region >= REGION_COUNT) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (int k = 0; k < REGION_WORDS; k++)
                        shadow_words[c.region * REGION_WORDS + k] = '0;
                end
            end
        endcase
        return r;
    endfunction

    // byte address mix: mostly allocated words, some at or just past the pointer, misaligned and noise
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned sel;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        logic [ADDR_W-1:0] a;
        sel = $urandom_range(99);
        r   = $urandom_range(REGION_COUNT - 1);
        lo  = r * REGION_WORDS;
        hi  = shadow_next_free[r] >> 2;
        if (sel < 70 && hi > lo) begin
            a = ADDR_W'($urandom_range(hi - 1, lo) * 4);
        end else if (sel < 80) begin
            a = ADDR_W'(shadow_next_free[r] + 4 * $urandom_range(2));
        end else if (sel < 90) begin
            a = ADDR_W'($urandom_range(TOTAL_BYTES - 1));
            a[1:0] = 2'($urandom_range(3, 1));
        end else begin
            a = ADDR_W'($urandom());
        end
        return a;
    endfunction

    // offer one transaction, with a random idle gap first, and record its prediction
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [REGION_W-1:0] region,
                             input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wval);
        int unsigned gap;
        mem_cmd_t item;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.cmd    = cmd;
        item.region = region;
        item.addr   = addr;
        item.wval   = wval;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, wval, addr, region};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(model_memory_op(item));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned sel;
        logic [CMD_W-1:0] cmd;
        logic [ADDR_W-1:0] addr;
        sel = $urandom_range(99);
        if (sel < 30)
            cmd = CMD_ALLOC;
        else if (sel < 62)
            cmd = CMD_READ;
        else if (sel < 95)
            cmd = CMD_WRITE;
        else
            cmd = CMD_CLEAR;
        if (cmd == CMD_READ || cmd == CMD_WRITE)
            addr = pick_address();
        else
            addr = ADDR_W'($urandom());
        send_item(cmd, REGION_W'($urandom_range(3)), addr, DATA_W'($urandom()));
    endtask

    // field extremes, every operation, range and alignment errors, clear region
    task automatic test_directed_access();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(CMD_READ,  2'd0, 16'd0,      32'h0);
        send_item(CMD_WRITE, 2'd1, 16'd16,     32'h1234_5678);
        send_item(CMD_READ,  2'd3, 16'hFFFF,   32'hFFFF_FFFF);
        send_item(CMD_WRITE, 2'd0, 16'd1026,   32'h0);
        send_item(CMD_READ,  2'd0, 16'd1024,   32'h0);
        send_item(CMD_ALLOC, 2'd0, 16'hFFFF,   32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 2'd1, 16'd0,      32'h0);
        send_item(CMD_ALLOC, 2'd2, 16'd0,      32'h0);
        send_item(CMD_ALLOC, 2'd3, 16'd0,      32'h0);
        send_item(CMD_WRITE, 2'd3, 16'd0,      32'h8000_0000);
        send_item(CMD_READ,  2'd0, 16'd0,      32'h0);
        send_item(CMD_WRITE, 2'd0, 16'd0,      32'h7FFF_FFFF);
        send_item(CMD_READ,  2'd0, 16'd0,      32'h0);
        send_item(CMD_WRITE, 2'd0, 16'd768,    32'hFFFF_FFFF);
        send_item(CMD_READ,  2'd0, 16'd768,    32'h0);
        send_item(CMD_READ,  2'd0, 16'd1,      32'h0);
        send_item(CMD_WRITE, 2'd0, 16'd2,      32'hDEAD_BEEF);
        send_item(CMD_READ,  2'd0, 16'd1023,   32'h0);
        // the word at the pointer of region 0, just past its allocated word
        send_item(CMD_READ,  2'd0, 16'd4,      32'h0);
        send_item(CMD_CLEAR, 2'd0, 16'hFFFF,   32'hFFFF_FFFF);
        send_item(CMD_READ,  2'd0, 16'd0,      32'h0);
        send_item(CMD_READ,  2'd0, 16'd768,    32'h0);
        send_item(CMD_CLEAR, 2'd3, 16'd0,      32'h0);
        send_item(CMD_READ,  2'd0, 16'd768,    32'h0);
        wait_drained();
    endtask

    // fill region 2 to its end, then allocate past it and touch its last word
    task automatic test_region_full();
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        while (shadow_next_free[2] < 3 * REGION_BYTES)
            send_item(CMD_ALLOC, 2'd2, ADDR_W'($urandom()), DATA_W'($urandom()));
        send_item(CMD_ALLOC, 2'd2, 16'd0, 32'h0);
        send_item(CMD_ALLOC, 2'd2, 16'd0, 32'h0);
        send_item(CMD_WRITE, 2'd0, 16'd764, 32'hA5A5_5A5A);
        send_item(CMD_READ,  2'd0, 16'd764, 32'h0);
        send_item(CMD_READ,  2'd0, 16'd512, 32'h0);
        send_item(CMD_CLEAR, 2'd2, 16'd0,   32'h0);
        send_item(CMD_READ,  2'd0, 16'd764, 32'h0);
        send_item(CMD_ALLOC, 2'd2, 16'd0,   32'h0);
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(negedge i_clk);
        rx_hold = HOLD_CYCLES;
        @(posedge i_clk);
        repeat (24) send_random_item();
        wait_drained();
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) begin
            send_random_item();
            // occasional full pause until the block is empty
            if ($urandom_range(99) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // receiver ready: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        mem_result_t exp_result;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, got status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                exp_result = pending_results.pop_front();
                if (m_axis_tuser !== exp_result.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp_result.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== exp_result.data) begin
                    $display("%0t: data mismatch, expected %h, got %h",
                             $time, exp_result.data, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int w = 0; w < TOTAL_WORDS; w++)
            shadow_words[w] = '0;
        for (int r = 0; r < REGION_COUNT; r++)
            shadow_next_free[r] = 11'(r * REGION_BYTES);
        // reset, then the block runs its clearing pass before taking transactions
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_access();
        test_region_full();
        test_backpressure();
        run_random_phase(0, 0);
        run_random_phase(66, 0);
        run_random_phase(0, 66);
        run_random_phase(12, 12);
        test_backpressure();

        wait_drained();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
